### hw/rtl/dsf_pkg.sv
// Shared types, constants and helper functions for the deblocking edge sample filter.
// Used by dsf_filter, deblock_edge_sample_filter and tb_top; depends on nothing else.
`default_nettype none

package dsf_pkg;

	localparam int unsigned SAMPLE_W   = 14;
	localparam int unsigned DEPTH_W    = 4;
	localparam int unsigned MIN_DEPTH  = 8;
	localparam int unsigned MAX_DEPTH  = 14;
	localparam int unsigned IN_DATA_W  = 152;
	localparam int unsigned OUT_DATA_W = 88;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef enum logic [0:0] {
		CFG_LUMA_DEPTH   = 1'b0,
		CFG_CHROMA_DEPTH = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [55:0] p_side;
		logic [55:0] q_side;
		logic [13:0] alpha_limit;
		logic [10:0] beta_limit;
		logic [2:0]  strength;
		logic [5:0]  clip_index;
		logic        chroma_style;
		logic        use_chroma_depth;
	} line_t;

	typedef struct packed {
		sample_t new_p0;
		sample_t new_p1;
		sample_t new_p2;
		sample_t new_q0;
		sample_t new_q1;
		sample_t new_q2;
		logic    was_filtered;
	} result_t;

	function automatic sample_t absd(input sample_t a, input sample_t b);
		if (a > b) begin
			return a - b;
		end
		return b - a;
	endfunction

	// Limits a signed value to [-lim, lim].
	function automatic logic signed [17:0] clip_sym(input logic signed [17:0] x,
			input logic [10:0] lim);
		logic signed [17:0] hi;
		hi = $signed({7'b0, lim});
		if (x > hi) begin
			return hi;
		end
		if (x < -hi) begin
			return -hi;
		end
		return x;
	endfunction

	// Limits a signed value to [0, hi].
	function automatic sample_t clip_sample(input logic signed [17:0] x, input sample_t hi);
		if (x < 18'sd0) begin
			return '0;
		end
		if (x > $signed({4'b0, hi})) begin
			return hi;
		end
		return x[SAMPLE_W-1:0];
	endfunction

	// tc0 clipping table; indexes above the last row read the last row.
	function automatic logic [4:0] tc0_lookup(input logic [5:0] idx, input logic [1:0] bs);
		logic [14:0] row;
		case (idx) inside
			[6'd0:6'd16]:  row = {5'd0,  5'd0,  5'd0};
			[6'd17:6'd20]: row = {5'd1,  5'd0,  5'd0};
			[6'd21:6'd22]: row = {5'd1,  5'd1,  5'd0};
			[6'd23:6'd26]: row = {5'd1,  5'd1,  5'd1};
			[6'd27:6'd30]: row = {5'd2,  5'd1,  5'd1};
			[6'd31:6'd32]: row = {5'd3,  5'd2,  5'd1};
			6'd33:         row = {5'd3,  5'd2,  5'd2};
			6'd34:         row = {5'd4,  5'd2,  5'd2};
			[6'd35:6'd36]: row = {5'd4,  5'd3,  5'd2};
			6'd37:         row = {5'd5,  5'd3,  5'd3};
			[6'd38:6'd39]: row = {5'd6,  5'd4,  5'd3};
			6'd40:         row = {5'd7,  5'd5,  5'd4};
			6'd41:         row = {5'd8,  5'd5,  5'd4};
			6'd42:         row = {5'd9,  5'd6,  5'd4};
			6'd43:         row = {5'd10, 5'd7,  5'd5};
			6'd44:         row = {5'd11, 5'd8,  5'd6};
			6'd45:         row = {5'd13, 5'd8,  5'd6};
			6'd46:         row = {5'd14, 5'd10, 5'd7};
			6'd47:         row = {5'd16, 5'd11, 5'd8};
			6'd48:         row = {5'd18, 5'd12, 5'd9};
			6'd49:         row = {5'd20, 5'd13, 5'd10};
			6'd50:         row = {5'd23, 5'd15, 5'd11};
			default:       row = {5'd25, 5'd17, 5'd13};
		endcase
		case (bs)
			2'd1:    return row[4:0];
			2'd2:    return row[9:5];
			2'd3:    return row[14:10];
			default: return 5'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

### hw/rtl/dsf_filter.sv
// Combinational edge filter for one line of eight samples: gates, strong and normal filters.
// Depends on dsf_pkg.
`default_nettype none

module dsf_filter (
	input  wire dsf_pkg::line_t   line,
	input  wire [3:0]             luma_depth,
	input  wire [3:0]             chroma_depth,
	output dsf_pkg::result_t      result
);

	dsf_pkg::sample_t p0, p1, p2, p3, q0, q1, q2, q3;
	dsf_pkg::sample_t ad_pq, ad_p10, ad_q10, ad_p20, ad_q20, near_lim;
	dsf_pkg::sample_t beta_ext, maxv;
	logic             gate_on, ap_ok, aq_ok, near, strong_p, strong_q;
	logic             is_strong, is_normal;

	logic [16:0]      sp0, sp1, sp2, sq0, sq1, sq2, cp0, cq0;

	logic [3:0]       depth_raw, depth;
	logic [2:0]       dsh;
	logic [14:0]      mx;
	logic [10:0]      tc0, tc;
	logic [14:0]      avg_sum;
	dsf_pkg::sample_t avg;
	logic signed [17:0] dq, draw, dshr, delta, np0_s, nq0_s;
	logic signed [17:0] tp, tq, adj_p, adj_q, np1_s, nq1_s;

	function automatic logic [16:0] ext(input dsf_pkg::sample_t x);
		return {3'b0, x};
	endfunction

	function automatic logic signed [17:0] sx(input dsf_pkg::sample_t x);
		return $signed({4'b0, x});
	endfunction

	always_comb begin
		p0 = line.p_side[13:0];
		p1 = line.p_side[27:14];
		p2 = line.p_side[41:28];
		p3 = line.p_side[55:42];
		q0 = line.q_side[13:0];
		q1 = line.q_side[27:14];
		q2 = line.q_side[41:28];
		q3 = line.q_side[55:42];

		beta_ext = {3'b0, line.beta_limit};
		ad_pq    = dsf_pkg::absd(p0, q0);
		ad_p10   = dsf_pkg::absd(p1, p0);
		ad_q10   = dsf_pkg::absd(q1, q0);
		ad_p20   = dsf_pkg::absd(p2, p0);
		ad_q20   = dsf_pkg::absd(q2, q0);
		ap_ok    = ad_p20 < beta_ext;
		aq_ok    = ad_q20 < beta_ext;
		near_lim = {2'b0, line.alpha_limit[13:2]} + 14'd2;
		near     = ad_pq < near_lim;

		gate_on = (line.strength >= 3'd1) && (line.strength <= 3'd4)
			&& (ad_pq < line.alpha_limit) && (ad_p10 < beta_ext) && (ad_q10 < beta_ext);
		is_strong = gate_on && (line.strength == 3'd4);
		is_normal = gate_on && (line.strength != 3'd4);
		strong_p  = !line.chroma_style && ap_ok && near;
		strong_q  = !line.chroma_style && aq_ok && near;

		// Strong filter taps.
		sp0 = ext(p2) + (ext(p1) << 1) + (ext(p0) << 1) + (ext(q0) << 1) + ext(q1) + 17'd4;
		sp1 = ext(p2) + ext(p1) + ext(p0) + ext(q0) + 17'd2;
		sp2 = (ext(p3) << 1) + ext(p2) + (ext(p2) << 1) + ext(p1) + ext(p0) + ext(q0) + 17'd4;
		sq0 = ext(p1) + (ext(p0) << 1) + (ext(q0) << 1) + (ext(q1) << 1) + ext(q2) + 17'd4;
		sq1 = ext(p0) + ext(q0) + ext(q1) + ext(q2) + 17'd2;
		sq2 = (ext(q3) << 1) + ext(q2) + (ext(q2) << 1) + ext(q1) + ext(q0) + ext(p0) + 17'd4;
		cp0 = (ext(p1) << 1) + ext(p0) + ext(q1) + 17'd2;
		cq0 = (ext(q1) << 1) + ext(q0) + ext(p1) + 17'd2;

		// Normal filter.
		depth_raw = line.use_chroma_depth ? chroma_depth : luma_depth;
		if (depth_raw < 4'(dsf_pkg::MIN_DEPTH)) begin
			depth = 4'(dsf_pkg::MIN_DEPTH);
		end else if (depth_raw > 4'(dsf_pkg::MAX_DEPTH)) begin
			depth = 4'(dsf_pkg::MAX_DEPTH);
		end else begin
			depth = depth_raw;
		end
		dsh  = 3'(depth - 4'(dsf_pkg::MIN_DEPTH));
		mx   = (15'd1 << depth) - 15'd1;
		maxv = mx[13:0];

		tc0 = {6'b0, dsf_pkg::tc0_lookup(line.clip_index, line.strength[1:0])} << dsh;
		if (line.chroma_style) begin
			tc = tc0 + 11'd1;
		end else begin
			tc = tc0 + 11'(ap_ok) + 11'(aq_ok);
		end

		dq    = sx(q0) - sx(p0);
		draw  = (dq <<< 2) + (sx(p1) - sx(q1)) + 18'sd4;
		dshr  = draw >>> 3;
		delta = dsf_pkg::clip_sym(dshr, tc);
		np0_s = sx(p0) + delta;
		nq0_s = sx(q0) - delta;

		avg_sum = {1'b0, p0} + {1'b0, q0} + 15'd1;
		avg     = avg_sum[14:1];
		tp      = sx(p2) + sx(avg) - (sx(p1) <<< 1);
		tq      = sx(q2) + sx(avg) - (sx(q1) <<< 1);
		adj_p   = dsf_pkg::clip_sym(tp >>> 1, tc0);
		adj_q   = dsf_pkg::clip_sym(tq >>> 1, tc0);
		np1_s   = sx(p1) + adj_p;
		nq1_s   = sx(q1) + adj_q;

		result.new_p0       = p0;
		result.new_p1       = p1;
		result.new_p2       = p2;
		result.new_q0       = q0;
		result.new_q1       = q1;
		result.new_q2       = q2;
		result.was_filtered = gate_on;

		if (is_strong) begin
			if (strong_p) begin
				result.new_p0 = sp0[16:3];
				result.new_p1 = sp1[15:2];
				result.new_p2 = sp2[16:3];
			end else begin
				result.new_p0 = cp0[15:2];
			end
			if (strong_q) begin
				result.new_q0 = sq0[16:3];
				result.new_q1 = sq1[15:2];
				result.new_q2 = sq2[16:3];
			end else begin
				result.new_q0 = cq0[15:2];
			end
		end else if (is_normal) begin
			result.new_p0 = dsf_pkg::clip_sample(np0_s, maxv);
			result.new_q0 = dsf_pkg::clip_sample(nq0_s, maxv);
			if (!line.chroma_style && ap_ok) begin
				result.new_p1 = dsf_pkg::clip_sample(np1_s, dsf_pkg::SAMPLE_MAX);
			end
			if (!line.chroma_style && aq_ok) begin
				result.new_q1 = dsf_pkg::clip_sample(nq1_s, dsf_pkg::SAMPLE_MAX);
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/deblock_edge_sample_filter.sv
// An accepted item passes through two register stages (input register, result register)
// before its result reaches the master side. Throughput: one item per cycle while the
// master side accepts results; the result register lets the input side keep taking items.
// Reset clears both valid flags and sets both bit depth registers to 8.
// Top level of the deblocking edge sample filter; depends on dsf_pkg and dsf_filter.
`default_nettype none

module deblock_edge_sample_filter (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// p_side, q_side, alpha_limit, beta_limit, strength, clip_index, zero pad
	input  wire [dsf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// chroma_style, use_chroma_depth
	input  wire [1:0]                         s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// new_p0, new_p1, new_p2, new_q0, new_q1, new_q2, zero pad
	output logic [dsf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// was_filtered
	output logic                              m_axis_tuser,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [0:0]                         cfg_index,
	input  wire [3:0]                         cfg_data
);

	dsf_pkg::line_t   line_s1;
	logic             valid_s1;
	dsf_pkg::result_t result_s2;
	dsf_pkg::result_t result_c;
	logic             valid_s2;
	logic             adv;
	logic [3:0]       luma_depth_q;
	logic [3:0]       chroma_depth_q;

	assign adv           = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_depth_q   <= 4'(dsf_pkg::MIN_DEPTH);
			chroma_depth_q <= 4'(dsf_pkg::MIN_DEPTH);
		end else if (cfg_valid) begin
			unique case (dsf_pkg::cfg_index_t'(cfg_index))
				dsf_pkg::CFG_LUMA_DEPTH:   luma_depth_q   <= cfg_data;
				dsf_pkg::CFG_CHROMA_DEPTH: chroma_depth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			line_s1.p_side           <= s_axis_tdata[55:0];
			line_s1.q_side           <= s_axis_tdata[111:56];
			line_s1.alpha_limit      <= s_axis_tdata[125:112];
			line_s1.beta_limit       <= s_axis_tdata[136:126];
			line_s1.strength         <= s_axis_tdata[139:137];
			line_s1.clip_index       <= s_axis_tdata[145:140];
			line_s1.chroma_style     <= s_axis_tuser[0];
			line_s1.use_chroma_depth <= s_axis_tuser[1];
		end
		if (adv && valid_s1) begin
			result_s2 <= result_c;
		end
	end

	dsf_filter u_filter (
		.line         (line_s1),
		.luma_depth   (luma_depth_q),
		.chroma_depth (chroma_depth_q),
		.result       (result_c)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0, result_s2.new_q2, result_s2.new_q1, result_s2.new_q0,
		result_s2.new_p2, result_s2.new_p1, result_s2.new_p0};
	assign m_axis_tuser  = result_s2.was_filtered;

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for deblock_edge_sample_filter: directed and random edge lines,
// predicted in the bench and compared per result; the random runs add idling and back-pressure.
// Depends on dsf_pkg and the deblock_edge_sample_filter RTL.
`default_nettype none

module tb_top;
	import dsf_pkg::*;

	localparam int BS_OFF      = 0;
	localparam int BS_STRONG   = 4;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [1:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [0:0]            cfg_index;
	logic [3:0]            cfg_data;

	result_t     filtered_lines [$];
	int unsigned mismatches = 0;
	int          quiet_cycles = 0;
	logic [3:0]  luma_depth_reg = 4'd8;
	logic [3:0]  chroma_depth_reg = 4'd8;
	logic [3:0]  gen_luma;
	logic [3:0]  gen_chroma;
	int          send_idle;
	int          recv_stall;
	logic        hold_on;

	int tc0_bs1 [52] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 2, 2, 2, 2, 3, 3, 3,
		4, 4, 4, 5, 6, 6, 7, 8, 9, 10, 11, 13};
	int tc0_bs2 [52] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 2, 2, 2, 2, 3, 3, 3, 4, 4,
		5, 5, 6, 7, 8, 8, 10, 11, 12, 13, 15, 17};
	int tc0_bs3 [52] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1,
		1, 1, 1, 1, 1, 1, 1, 2, 2, 2, 2, 3, 3, 3, 4, 4, 4, 5, 6, 6,
		7, 8, 9, 10, 11, 13, 14, 16, 18, 20, 23, 25};

	deblock_edge_sample_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int gap_of(input int a, input int b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic int limit_to(input int lo, input int hi, input int x);
		if (x < lo) begin
			return lo;
		end
		if (x > hi) begin
			return hi;
		end
		return x;
	endfunction

	function automatic int eff_depth(input logic [3:0] d);
		return limit_to(int'(MIN_DEPTH), int'(MAX_DEPTH), int'(d));
	endfunction

	function automatic result_t filter_line(input line_t ln, input logic [3:0] luma_d,
			input logic [3:0] chroma_d);
		int p [4];
		int q [4];
		int alpha, beta, bs, row, depth, ap, aq, tc0, tc, delta, maxv, avg;
		int np0, np1, np2, nq0, nq1, nq2;
		bit near;
		result_t r;
		for (int i = 0; i < 4; i++) begin
			p[i] = int'(ln.p_side[SAMPLE_W*i +: SAMPLE_W]);
			q[i] = int'(ln.q_side[SAMPLE_W*i +: SAMPLE_W]);
		end
		alpha = int'(ln.alpha_limit);
		beta = int'(ln.beta_limit);
		bs = int'(ln.strength);
		row = (ln.clip_index > 6'd51) ? 51 : int'(ln.clip_index);
		depth = eff_depth(ln.use_chroma_depth ? chroma_d : luma_d);
		np0 = p[0];
		np1 = p[1];
		np2 = p[2];
		nq0 = q[0];
		nq1 = q[1];
		nq2 = q[2];
		r.was_filtered = 1'b0;
		if (bs > BS_OFF && bs <= BS_STRONG && gap_of(p[0], q[0]) < alpha &&
				gap_of(p[1], p[0]) < beta && gap_of(q[1], q[0]) < beta) begin
			ap = gap_of(p[2], p[0]);
			aq = gap_of(q[2], q[0]);
			r.was_filtered = 1'b1;
			if (bs == BS_STRONG) begin
				near = gap_of(p[0], q[0]) < (alpha >> 2) + 2;
				if (!ln.chroma_style && ap < beta && near) begin
					np0 = (p[2] + 2 * p[1] + 2 * p[0] + 2 * q[0] + q[1] + 4) >> 3;
					np1 = (p[2] + p[1] + p[0] + q[0] + 2) >> 2;
					np2 = (2 * p[3] + 3 * p[2] + p[1] + p[0] + q[0] + 4) >> 3;
				end else begin
					np0 = (2 * p[1] + p[0] + q[1] + 2) >> 2;
				end
				if (!ln.chroma_style && aq < beta && near) begin
					nq0 = (p[1] + 2 * p[0] + 2 * q[0] + 2 * q[1] + q[2] + 4) >> 3;
					nq1 = (p[0] + q[0] + q[1] + q[2] + 2) >> 2;
					nq2 = (2 * q[3] + 3 * q[2] + q[1] + q[0] + p[0] + 4) >> 3;
				end else begin
					nq0 = (2 * q[1] + q[0] + p[1] + 2) >> 2;
				end
			end else begin
				case (bs)
					1:       tc0 = tc0_bs1[row];
					2:       tc0 = tc0_bs2[row];
					default: tc0 = tc0_bs3[row];
				endcase
				tc0 = tc0 << (depth - 8);
				maxv = (1 << depth) - 1;
				if (ln.chroma_style) begin
					tc = tc0 + 1;
				end else begin
					tc = tc0 + int'(ap < beta) + int'(aq < beta);
				end
				delta = limit_to(-tc, tc, ((q[0] - p[0]) * 4 + (p[1] - q[1]) + 4) >>> 3);
				np0 = limit_to(0, maxv, p[0] + delta);
				nq0 = limit_to(0, maxv, q[0] - delta);
				avg = (p[0] + q[0] + 1) >> 1;
				if (!ln.chroma_style && ap < beta) begin
					np1 = limit_to(0, (1 << SAMPLE_W) - 1,
						p[1] + limit_to(-tc0, tc0, (p[2] + avg - 2 * p[1]) >>> 1));
				end
				if (!ln.chroma_style && aq < beta) begin
					nq1 = limit_to(0, (1 << SAMPLE_W) - 1,
						q[1] + limit_to(-tc0, tc0, (q[2] + avg - 2 * q[1]) >>> 1));
				end
			end
		end
		r.new_p0 = sample_t'(np0);
		r.new_p1 = sample_t'(np1);
		r.new_p2 = sample_t'(np2);
		r.new_q0 = sample_t'(nq0);
		r.new_q1 = sample_t'(nq1);
		r.new_q2 = sample_t'(nq2);
		return r;
	endfunction

	function automatic logic [55:0] quad(input int s0, input int s1, input int s2, input int s3);
		return {sample_t'(s3), sample_t'(s2), sample_t'(s1), sample_t'(s0)};
	endfunction

	function automatic line_t line_of(input logic [55:0] ps, input logic [55:0] qs,
			input int alpha, input int beta, input int bs, input int idx,
			input bit cs, input bit cd);
		line_t ln;
		ln.p_side = ps;
		ln.q_side = qs;
		ln.alpha_limit = 14'(alpha);
		ln.beta_limit = 11'(beta);
		ln.strength = 3'(bs);
		ln.clip_index = 6'(idx);
		ln.chroma_style = cs;
		ln.use_chroma_depth = cd;
		return ln;
	endfunction

	function automatic int step_from(input int x, input int r, input int maxv);
		return limit_to(0, maxv, x + int'($urandom_range(0, 2 * r)) - r);
	endfunction

	function automatic line_t random_line(input logic [3:0] luma_d, input logic [3:0] chroma_d);
		line_t ln;
		int depth, maxv, alpha, beta, pick;
		int p [4];
		int q [4];
		ln.chroma_style = 1'($urandom_range(0, 1));
		ln.use_chroma_depth = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0) begin
			ln.clip_index = 6'($urandom_range(52, 63));
		end else begin
			ln.clip_index = 6'($urandom_range(0, 51));
		end
		pick = $urandom_range(0, 15);
		if (pick < 5) begin
			ln.strength = 3'(BS_STRONG);
		end else if (pick < 13) begin
			ln.strength = 3'($urandom_range(1, 3));
		end else begin
			ln.strength = 3'($urandom_range(0, 7));
		end
		if ($urandom_range(0, 9) < 2) begin
			ln.p_side = 56'({$urandom, $urandom});
			ln.q_side = 56'({$urandom, $urandom});
			ln.alpha_limit = 14'($urandom);
			ln.beta_limit = 11'($urandom);
			return ln;
		end
		depth = eff_depth(ln.use_chroma_depth ? chroma_d : luma_d);
		maxv = (1 << depth) - 1;
		alpha = $urandom_range(1, 255 << (depth - 8));
		beta = $urandom_range(1, 18 << (depth - 8));
		p[0] = $urandom_range(0, maxv);
		q[0] = step_from(p[0], $urandom_range(0, 1) ? (alpha >> 2) + 2 : alpha, maxv);
		p[1] = step_from(p[0], beta, maxv);
		q[1] = step_from(q[0], beta, maxv);
		p[2] = step_from(p[0], beta, maxv);
		q[2] = step_from(q[0], beta, maxv);
		p[3] = step_from(p[2], beta, maxv);
		q[3] = step_from(q[2], beta, maxv);
		ln.p_side = quad(p[0], p[1], p[2], p[3]);
		ln.q_side = quad(q[0], q[1], q[2], q[3]);
		ln.alpha_limit = 14'(alpha);
		ln.beta_limit = 11'(beta);
		return ln;
	endfunction

	task automatic send_line(input line_t ln);
		if ($urandom_range(0, 99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, ln.clip_index, ln.strength, ln.beta_limit, ln.alpha_limit,
			ln.q_side, ln.p_side};
		s_axis_tuser <= {ln.use_chroma_depth, ln.chroma_style};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (filtered_lines.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [3:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_depths(input logic [3:0] luma, input logic [3:0] chroma);
		drain();
		write_reg(CFG_LUMA_DEPTH, luma);
		write_reg(CFG_CHROMA_DEPTH, chroma);
		cfg_valid <= 1'b0;
		gen_luma = luma;
		gen_chroma = chroma;
	endtask

	task automatic test_passthrough();
		send_line(line_of(quad(100, 101, 102, 103), quad(104, 105, 106, 107), 20, 5,
			BS_OFF, 30, 0, 0));
		send_line(line_of(quad(100, 101, 102, 103), quad(104, 105, 106, 107), 20, 5,
			5, 30, 0, 0));
		send_line(line_of(quad(100, 101, 102, 103), quad(104, 105, 106, 107), 20, 5,
			6, 30, 1, 0));
		send_line(line_of(quad(100, 101, 102, 103), quad(104, 105, 106, 107), 20, 5,
			7, 30, 0, 1));
		send_line(line_of(quad(100, 101, 102, 103), quad(120, 121, 122, 123), 20, 5,
			BS_STRONG, 30, 0, 0));
		send_line(line_of(quad(100, 105, 102, 103), quad(104, 105, 106, 107), 20, 5,
			2, 30, 0, 0));
		send_line(line_of(quad(100, 101, 102, 103), quad(104, 99, 106, 107), 20, 5,
			2, 30, 0, 0));
		send_line(line_of('1, '1, 16383, 2047, 7, 63, 1, 1));
		send_line(line_of('0, '0, 0, 0, 3, 0, 0, 0));
		drain();
	endtask

	task automatic test_strong();
		send_line(line_of(quad(100, 102, 104, 106), quad(103, 105, 107, 109), 40, 10,
			BS_STRONG, 20, 0, 0));
		send_line(line_of(quad(100, 102, 104, 106), quad(130, 132, 134, 136), 40, 10,
			BS_STRONG, 20, 0, 0));
		send_line(line_of(quad(100, 102, 104, 106), quad(103, 105, 140, 0), 40, 10,
			BS_STRONG, 20, 0, 0));
		send_line(line_of(quad(100, 102, 104, 106), quad(103, 105, 107, 109), 40, 10,
			BS_STRONG, 20, 1, 0));
		send_line(line_of('1, '1, 1, 1, BS_STRONG, 51, 0, 1));
		drain();
	endtask

	task automatic test_normal();
		send_line(line_of(quad(100, 104, 108, 110), quad(120, 118, 116, 112), 40, 10,
			1, 51, 0, 0));
		send_line(line_of(quad(100, 104, 108, 110), quad(120, 118, 116, 112), 40, 10,
			2, 63, 0, 1));
		send_line(line_of(quad(100, 104, 108, 110), quad(120, 118, 116, 112), 40, 10,
			3, 0, 0, 0));
		send_line(line_of(quad(130, 128, 126, 124), quad(110, 112, 114, 116), 40, 10,
			3, 40, 1, 0));
		send_line(line_of(quad(300, 302, 304, 0), quad(310, 309, 308, 0), 40, 10,
			3, 51, 0, 0));
		send_line(line_of(quad(1, 0, 0, 0), quad(0, 200, 0, 0), 10, 250, 3, 51, 0, 0));
		send_line(line_of(quad(16380, 16383, 16383, 16383), quad(16383, 16382, 16383, 16383),
			40, 10, 3, 51, 0, 0));
		drain();
	endtask

	task automatic run_random(input int count, input int idle_pct, input int stall_pct);
		send_idle = idle_pct;
		recv_stall = stall_pct;
		repeat (count) send_line(random_line(gen_luma, gen_chroma));
		drain();
	endtask

	task automatic test_backpressure(input int count);
		send_idle = 0;
		recv_stall = 0;
		fork
			begin
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
		join_none
		repeat (count) send_line(random_line(gen_luma, gen_chroma));
		drain();
	endtask

	always @(posedge clk) begin
		m_axis_tready <= !hold_on && ($urandom_range(0, 99) >= recv_stall);
	end

	always @(posedge clk) begin : scoreboard
		line_t   seen;
		result_t want;
		result_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.new_p0 = m_axis_tdata[13:0];
				got.new_p1 = m_axis_tdata[27:14];
				got.new_p2 = m_axis_tdata[41:28];
				got.new_q0 = m_axis_tdata[55:42];
				got.new_q1 = m_axis_tdata[69:56];
				got.new_q2 = m_axis_tdata[83:70];
				got.was_filtered = m_axis_tuser;
				if (filtered_lines.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result with nothing expected: p %0d %0d %0d q %0d %0d %0d f %0d",
							got.new_p0, got.new_p1, got.new_p2, got.new_q0, got.new_q1,
							got.new_q2, got.was_filtered);
					end
				end else begin
					want = filtered_lines.pop_front();
					if (want !== got) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("expected p %0d %0d %0d q %0d %0d %0d f %0d, got p %0d %0d %0d q %0d %0d %0d f %0d",
								want.new_p0, want.new_p1, want.new_p2, want.new_q0,
								want.new_q1, want.new_q2, want.was_filtered,
								got.new_p0, got.new_p1, got.new_p2, got.new_q0,
								got.new_q1, got.new_q2, got.was_filtered);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				seen.p_side = s_axis_tdata[55:0];
				seen.q_side = s_axis_tdata[111:56];
				seen.alpha_limit = s_axis_tdata[125:112];
				seen.beta_limit = s_axis_tdata[136:126];
				seen.strength = s_axis_tdata[139:137];
				seen.clip_index = s_axis_tdata[145:140];
				seen.chroma_style = s_axis_tuser[0];
				seen.use_chroma_depth = s_axis_tuser[1];
				filtered_lines.push_back(filter_line(seen, luma_depth_reg, chroma_depth_reg));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_LUMA_DEPTH:   luma_depth_reg = cfg_data;
					CFG_CHROMA_DEPTH: chroma_depth_reg = cfg_data;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
				$display("deblock_edge_sample_filter: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_on = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		gen_luma = 4'd8;
		gen_chroma = 4'd8;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_passthrough();
		test_strong();
		test_normal();
		set_depths(4'd8, 4'd14);
		run_random(280, 0, 0);
		set_depths(4'd14, 4'd8);
		run_random(280, 78, 0);
		set_depths(4'd11, 4'd9);
		run_random(280, 0, 78);
		set_depths(4'd15, 4'd0);
		run_random(280, 20, 20);
		set_depths(4'd12, 4'd13);
		test_backpressure(200);
		set_depths(4'd10, 4'd14);
		run_random(260, 20, 20);
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("deblock_edge_sample_filter: match");
		end else begin
			$display("deblock_edge_sample_filter: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/dsf_pkg.sv
hw/rtl/dsf_filter.sv
hw/rtl/deblock_edge_sample_filter.sv
verif/tb_top.sv
